[src/ogic_pkg.sv]
// Shared types and constants for the online grid island counter.
// No dependencies; used by the interfaces, the RAM users and the top level.
package ogic_pkg;

    localparam int COORD_W = 6;
    localparam int GRID_W  = 7;
    localparam int COUNT_W = 12;
    localparam int CFG_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [GRID_W-1:0]  GRID_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 12'hFFF;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_NBR,
        ST_NBR_RD,
        ST_FIND,
        ST_LINK,
        ST_EMIT
    } t_state;

endpackage

[src/ogic_if.sv]
// Valid/ready channel interfaces for cell words in and island count words out.
// Depends on ogic_pkg.
interface ogic_cell_if;
    logic                         valid;
    logic                         ready;
    logic [ogic_pkg::COORD_W-1:0] cell_row;
    logic [ogic_pkg::COORD_W-1:0] cell_col;

    modport source(output valid, output cell_row, output cell_col, input ready);
    modport sink(input valid, input cell_row, input cell_col, output ready);
endinterface

interface ogic_count_if;
    logic                         valid;
    logic                         ready;
    logic [ogic_pkg::COUNT_W-1:0] island_count;

    modport source(output valid, output island_count, input ready);
    modport sink(input valid, input island_count, output ready);
endinterface

[src/online_grid_island_counter.sv]
// Online grid island counter top level: APB register port, sequencer, cell memory.
// Depends on ogic_pkg, ogic_if (ogic_cell_if, ogic_count_if) and ogic_ram.
//
// Each accepted cell word marks one cell of the grid as land and merges it with its
// land neighbors through a union-find parent memory; one count word follows with the
// number of islands, saturated at 4095. Cells outside grid_rows x grid_cols, or already
// land, produce no count word. After reset the block clears the cell memory, one entry
// per cycle, all MAX_ROWS*MAX_COLS entries (4096 by default), before taking the first
// cell word. A cell outside the grid is dropped; one already land is read, then dropped.
// A new land cell is written as its own root; for each of the four directions the
// neighbor is skipped if outside the grid, else read, and if it is land its parent chain
// is walked to its root, one read of the single read port per step, and the roots linked.
// The count word is held in an output register, so the next cell word is taken while it
// waits; a new count word waits until that register has drained.
module online_grid_island_counter #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ogic_pkg::CFG_AW-1:0]   paddr,
    input  logic [ogic_pkg::APB_DW-1:0]   pwdata,
    output logic [ogic_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    ogic_cell_if.sink                     i_cell,
    ogic_count_if.source                  o_count
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MAXD   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DIM_W  = ($clog2(MAXD + 1) > ogic_pkg::GRID_W) ?
                            $clog2(MAXD + 1) : ogic_pkg::GRID_W;
    localparam int CNT_W  = CELL_W + 1;
    localparam int SAT_W  = (CNT_W > ogic_pkg::COUNT_W) ? CNT_W : ogic_pkg::COUNT_W;
    localparam int WORD_W = CELL_W + 1;

    localparam logic [CELL_W-1:0] COL_STEP  = CELL_W'(MAX_COLS);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [DIM_W-1:0]  ROWS_CAP  = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0]  COLS_CAP  = DIM_W'(MAX_COLS);

    ogic_pkg::t_state r_state, n_state;
    ogic_pkg::t_dir   r_dir, n_dir;

    logic [ogic_pkg::GRID_W-1:0]  r_rows, n_rows;
    logic [ogic_pkg::GRID_W-1:0]  r_cols, n_cols;
    logic [ogic_pkg::COORD_W-1:0] r_row, n_row;
    logic [ogic_pkg::COORD_W-1:0] r_col, n_col;
    logic [CELL_W-1:0]            r_cell, n_cell;
    logic [CELL_W-1:0]            r_cur, n_cur;
    logic [CELL_W-1:0]            r_ra, n_ra;
    logic [CELL_W-1:0]            r_clr, n_clr;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_out_valid, n_out_valid;
    logic [ogic_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic [DIM_W-1:0]  rows_lim, cols_lim;
    logic [DIM_W-1:0]  in_row_ext, in_col_ext;
    logic              in_inside;
    logic [31:0]       in_prod;
    logic [CELL_W-1:0] in_cell;
    logic              nb_ok;
    logic [CELL_W-1:0] nb_cell;
    logic              last_dir;
    logic              out_free;
    logic [SAT_W-1:0]  count_ext;

    logic              wr_en, rd_en;
    logic [CELL_W-1:0] wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;
    logic              rd_land;
    logic [CELL_W-1:0] rd_par;

    ogic_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CELLS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_land = rd_data[CELL_W];
    assign rd_par  = rd_data[CELL_W-1:0];

    // APB registers
    assign pready = 1'b1;

    always_comb begin
        unique case (ogic_pkg::t_reg'(paddr[2]))
            ogic_pkg::REG_ROWS: prdata = ogic_pkg::APB_DW'(r_rows);
            ogic_pkg::REG_COLS: prdata = ogic_pkg::APB_DW'(r_cols);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (psel && penable && pwrite) begin
            unique case (ogic_pkg::t_reg'(paddr[2]))
                ogic_pkg::REG_ROWS: n_rows = pwdata[ogic_pkg::GRID_W-1:0];
                ogic_pkg::REG_COLS: n_cols = pwdata[ogic_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // grid bounds and cell addressing
    assign rows_lim   = (DIM_W'(r_rows) < ROWS_CAP) ? DIM_W'(r_rows) : ROWS_CAP;
    assign cols_lim   = (DIM_W'(r_cols) < COLS_CAP) ? DIM_W'(r_cols) : COLS_CAP;
    assign in_row_ext = DIM_W'(i_cell.cell_row);
    assign in_col_ext = DIM_W'(i_cell.cell_col);
    assign in_inside  = (in_row_ext < rows_lim) && (in_col_ext < cols_lim);
    assign in_prod    = 32'(i_cell.cell_row) * 32'(MAX_COLS) + 32'(i_cell.cell_col);
    assign in_cell    = in_prod[CELL_W-1:0];

    always_comb begin
        case (r_dir)
            ogic_pkg::DIR_UP: begin
                nb_ok   = (r_row != '0);
                nb_cell = r_cell - COL_STEP;
            end
            ogic_pkg::DIR_DOWN: begin
                nb_ok   = (DIM_W'(r_row) + DIM_W'(1)) < rows_lim;
                nb_cell = r_cell + COL_STEP;
            end
            ogic_pkg::DIR_LEFT: begin
                nb_ok   = (r_col != '0);
                nb_cell = r_cell - CELL_W'(1);
            end
            default: begin
                nb_ok   = (DIM_W'(r_col) + DIM_W'(1)) < cols_lim;
                nb_cell = r_cell + CELL_W'(1);
            end
        endcase
    end

    assign last_dir  = (r_dir == ogic_pkg::DIR_RIGHT);
    assign out_free  = !r_out_valid || o_count.ready;
    assign count_ext = SAT_W'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ogic_pkg::ST_CLEAR: begin
                if (r_clr == LAST_CELL) n_state = ogic_pkg::ST_IDLE;
            end
            ogic_pkg::ST_IDLE: begin
                if (i_cell.valid && in_inside) n_state = ogic_pkg::ST_CHECK;
            end
            ogic_pkg::ST_CHECK: begin
                n_state = rd_land ? ogic_pkg::ST_IDLE : ogic_pkg::ST_NBR;
            end
            ogic_pkg::ST_NBR: begin
                if (nb_ok) begin
                    n_state = ogic_pkg::ST_NBR_RD;
                end else if (last_dir) begin
                    n_state = ogic_pkg::ST_EMIT;
                end
            end
            ogic_pkg::ST_NBR_RD: begin
                if (!rd_land) begin
                    n_state = last_dir ? ogic_pkg::ST_EMIT : ogic_pkg::ST_NBR;
                end else if (rd_par == r_cur) begin
                    n_state = ogic_pkg::ST_LINK;
                end else begin
                    n_state = ogic_pkg::ST_FIND;
                end
            end
            ogic_pkg::ST_FIND: begin
                if (rd_par == r_cur) n_state = ogic_pkg::ST_LINK;
            end
            ogic_pkg::ST_LINK: begin
                n_state = last_dir ? ogic_pkg::ST_EMIT : ogic_pkg::ST_NBR;
            end
            ogic_pkg::ST_EMIT: begin
                if (out_free) n_state = ogic_pkg::ST_IDLE;
            end
            default: n_state = ogic_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory port and output register
    always_comb begin
        n_dir       = r_dir;
        n_row       = r_row;
        n_col       = r_col;
        n_cell      = r_cell;
        n_cur       = r_cur;
        n_ra        = r_ra;
        n_clr       = r_clr;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_count.ready;
        n_out_count = r_out_count;
        wr_en       = 1'b0;
        wr_addr     = r_cell;
        wr_data     = {1'b1, r_cell};
        rd_en       = 1'b0;
        rd_addr     = r_cur;
        unique case (r_state) inside
            ogic_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + CELL_W'(1);
            end
            ogic_pkg::ST_IDLE: begin
                rd_addr = in_cell;
                if (i_cell.valid && in_inside) begin
                    rd_en  = 1'b1;
                    n_row  = i_cell.cell_row;
                    n_col  = i_cell.cell_col;
                    n_cell = in_cell;
                end
            end
            ogic_pkg::ST_CHECK: begin
                if (!rd_land) begin
                    wr_en   = 1'b1;
                    n_ra    = r_cell;
                    n_count = r_count + CNT_W'(1);
                    n_dir   = ogic_pkg::DIR_UP;
                end
            end
            ogic_pkg::ST_NBR: begin
                rd_addr = nb_cell;
                if (nb_ok) begin
                    rd_en = 1'b1;
                    n_cur = nb_cell;
                end else if (!last_dir) begin
                    n_dir = ogic_pkg::t_dir'(r_dir + 2'd1);
                end
            end
            ogic_pkg::ST_NBR_RD, ogic_pkg::ST_FIND: begin
                rd_addr = rd_par;
                if (r_state == ogic_pkg::ST_NBR_RD && !rd_land) begin
                    if (!last_dir) n_dir = ogic_pkg::t_dir'(r_dir + 2'd1);
                end else if (rd_par != r_cur) begin
                    rd_en = 1'b1;
                    n_cur = rd_par;
                end
            end
            ogic_pkg::ST_LINK: begin
                // r_ra is the root of the new cell's set, r_cur the neighbor's root
                if (r_ra != r_cur) begin
                    wr_en   = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (r_ra < r_cur) begin
                        wr_addr = r_cur;
                        wr_data = {1'b1, r_ra};
                    end else begin
                        wr_addr = r_ra;
                        wr_data = {1'b1, r_cur};
                        n_ra    = r_cur;
                    end
                end
                if (!last_dir) n_dir = ogic_pkg::t_dir'(r_dir + 2'd1);
            end
            ogic_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = (count_ext > SAT_W'(ogic_pkg::COUNT_MAX)) ?
                                  ogic_pkg::COUNT_MAX : count_ext[ogic_pkg::COUNT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ogic_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rows      <= ogic_pkg::GRID_RESET;
            r_cols      <= ogic_pkg::GRID_RESET;
            r_dir       <= ogic_pkg::DIR_UP;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_dir       <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_cell      <= n_cell;
        r_cur       <= n_cur;
        r_ra        <= n_ra;
        r_out_count <= n_out_count;
    end

    assign i_cell.ready         = (r_state == ogic_pkg::ST_IDLE);
    assign o_count.valid        = r_out_valid;
    assign o_count.island_count = r_out_count;

endmodule

[src/ogic_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ogic_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[bench/island_count_checker.sv]
`timescale 1ns / 1ps
// Island count checker: follows grid register writes, predicts the island count for
// every accepted cell word that becomes new land and compares it with each count word.
// Depends on ogic_pkg and the ogic_cell_if / ogic_count_if interfaces.
module island_count_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ogic_pkg::CFG_AW-1:0]   paddr,
    input  logic [ogic_pkg::APB_DW-1:0]   pwdata,
    ogic_cell_if                          cell_mon,
    ogic_count_if                         count_mon,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_words
);

    localparam int ROWS_MAX = 64;
    localparam int COLS_MAX = 64;
    localparam int CELLS    = ROWS_MAX * COLS_MAX;

    bit                           is_land[CELLS];
    int                           up_link[CELLS];
    int                           islands;
    logic [ogic_pkg::GRID_W-1:0]  rows_reg;
    logic [ogic_pkg::GRID_W-1:0]  cols_reg;
    logic [ogic_pkg::COUNT_W-1:0] count_due[$];
    int                           errors;
    int                           words;

    function automatic int island_root(input int node);
        while (up_link[node] != node) begin
            up_link[node] = up_link[up_link[node]];
            node = up_link[node];
        end
        return node;
    endfunction

    // Returns 1 when the cell becomes new land; cnt is the island count afterwards.
    function automatic bit predict_island_count(input logic [ogic_pkg::COORD_W-1:0] r,
                                                input logic [ogic_pkg::COORD_W-1:0] c,
                                                output logic [ogic_pkg::COUNT_W-1:0] cnt);
        int rows;
        int cols;
        int idx;
        int nr;
        int nc;
        int ra;
        int rb;
        cnt  = '0;
        rows = (rows_reg > ogic_pkg::GRID_W'(ROWS_MAX)) ? ROWS_MAX : int'(rows_reg);
        cols = (cols_reg > ogic_pkg::GRID_W'(COLS_MAX)) ? COLS_MAX : int'(cols_reg);
        if (int'(r) >= rows || int'(c) >= cols) return 1'b0;
        idx = int'(r) * COLS_MAX + int'(c);
        if (is_land[idx]) return 1'b0;
        is_land[idx] = 1'b1;
        up_link[idx] = idx;
        islands++;
        for (int d = 0; d < 4; d++) begin
            nr = int'(r);
            nc = int'(c);
            case (ogic_pkg::t_dir'(d))
                ogic_pkg::DIR_UP:   nr = nr - 1;
                ogic_pkg::DIR_DOWN: nr = nr + 1;
                ogic_pkg::DIR_LEFT: nc = nc - 1;
                default:            nc = nc + 1;
            endcase
            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols
                && is_land[nr * COLS_MAX + nc]) begin
                ra = island_root(idx);
                rb = island_root(nr * COLS_MAX + nc);
                if (ra != rb) begin
                    up_link[ra] = rb;
                    islands--;
                end
            end
        end
        cnt = (islands > int'(ogic_pkg::COUNT_MAX)) ?
              ogic_pkg::COUNT_MAX : ogic_pkg::COUNT_W'(islands);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [ogic_pkg::COUNT_W-1:0] want;
        logic [ogic_pkg::COUNT_W-1:0] next_count;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                is_land[i] = 1'b0;
                up_link[i] = i;
            end
            islands  = 0;
            rows_reg = ogic_pkg::GRID_RESET;
            cols_reg = ogic_pkg::GRID_RESET;
            count_due.delete();
            errors   = 0;
            words    = 0;
        end else begin
            if (count_mon.valid === 1'b1 && count_mon.ready === 1'b1) begin
                words++;
                if (count_due.size() == 0) begin
                    errors++;
                    $display("%0t: count word with none expected: expected none actual %0d",
                             $time, count_mon.island_count);
                end else begin
                    want = count_due.pop_front();
                    if (want !== count_mon.island_count) begin
                        errors++;
                        $display("%0t: island_count mismatch: expected %0d actual %0d",
                                 $time, want, count_mon.island_count);
                    end
                end
            end
            if (cell_mon.valid === 1'b1 && cell_mon.ready === 1'b1) begin
                if (predict_island_count(cell_mon.cell_row, cell_mon.cell_col, next_count))
                    count_due = {count_due, next_count};
            end
            if (psel && penable && pwrite && pready) begin
                case (ogic_pkg::t_reg'(paddr[2]))
                    ogic_pkg::REG_ROWS: rows_reg = pwdata[ogic_pkg::GRID_W-1:0];
                    ogic_pkg::REG_COLS: cols_reg = pwdata[ogic_pkg::GRID_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= count_due.size();
        o_words   <= words;
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench top for online_grid_island_counter: clock, reset, APB grid setup, cell
// words with random gaps and count word back-pressure; verdict from the checker.
// Depends on ogic_pkg, ogic_if, the block and island_count_checker.
module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_WAIT   = 20;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [ogic_pkg::CFG_AW-1:0]  paddr   = '0;
    logic [ogic_pkg::APB_DW-1:0]  pwdata  = '0;
    logic [ogic_pkg::APB_DW-1:0]  prdata;
    logic                         pready;

    logic                         cell_valid = 1'b0;
    logic [ogic_pkg::COORD_W-1:0] cell_row_q = '0;
    logic [ogic_pkg::COORD_W-1:0] cell_col_q = '0;
    logic                         count_ready = 1'b0;

    int                 errors;
    int                 pending;
    int                 words;
    int unsigned        cycles = 0;
    bit                 no_idle = 1'b0;
    int                 stall_left = 0;
    int                 draw;

    ogic_cell_if  cell_bus();
    ogic_count_if count_bus();

    assign cell_bus.valid    = cell_valid;
    assign cell_bus.cell_row = cell_row_q;
    assign cell_bus.cell_col = cell_col_q;
    assign count_bus.ready   = count_ready;

    online_grid_island_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cell  (cell_bus),
        .o_count (count_bus)
    );

    island_count_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .cell_mon  (cell_bus),
        .count_mon (count_bus),
        .o_errors  (errors),
        .o_pending (pending),
        .o_words   (words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // count word sink: may stall after each accepted word (never in no-idle phases)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_ready <= 1'b0;
            stall_left  <= 0;
        end else if (count_bus.valid === 1'b1 && count_ready) begin
            draw = no_idle ? 0 : $urandom_range(0, 12);
            count_ready <= (draw == 0);
            stall_left  <= draw;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left  <= 0;
            count_ready <= 1'b1;
        end
    end

    task automatic send_cell(input logic [ogic_pkg::COORD_W-1:0] r,
                             input logic [ogic_pkg::COORD_W-1:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_row_q <= r;
        cell_col_q <= c;
        cell_valid <= 1'b1;
        @(posedge i_clk);
        while (cell_bus.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        cell_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input ogic_pkg::t_reg idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ogic_pkg::CFG_AW'(int'(idx) * 4);
        pwdata  <= ogic_pkg::APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input int rows_val, input int cols_val);
        wait_idle();
        write_reg(ogic_pkg::REG_ROWS, rows_val);
        write_reg(ogic_pkg::REG_COLS, cols_val);
    endtask

    // Mostly cells in a window of the grid so islands grow and merge; some anywhere.
    task automatic run_phase(input int rows_val, input int cols_val,
                             input int target, input int cap);
        int rows;
        int cols;
        int wh;
        int ww;
        int wr;
        int wc;
        int sel;
        int sent;
        int base;
        logic [ogic_pkg::COORD_W-1:0] r;
        logic [ogic_pkg::COORD_W-1:0] c;
        set_grid(rows_val, cols_val);
        no_idle <= ($urandom_range(0, 3) == 0);
        rows = (rows_val > 64) ? 64 : rows_val;
        cols = (cols_val > 64) ? 64 : cols_val;
        wh   = (rows > 16) ? 16 : rows;
        ww   = (cols > 16) ? 16 : cols;
        wr   = (rows > wh) ? $urandom_range(0, rows - wh) : 0;
        wc   = (cols > ww) ? $urandom_range(0, cols - ww) : 0;
        base = words;
        sent = 0;
        while (sent < cap && (target == 0 || words - base < target)) begin
            sel = $urandom_range(0, 99);
            if (rows == 0 || cols == 0 || sel < 15) begin
                r = ogic_pkg::COORD_W'($urandom);
                c = ogic_pkg::COORD_W'($urandom);
            end else if (sel < 30) begin
                r = ogic_pkg::COORD_W'($urandom_range(0, rows - 1));
                c = ogic_pkg::COORD_W'($urandom_range(0, cols - 1));
            end else begin
                r = ogic_pkg::COORD_W'(wr + $urandom_range(0, wh - 1));
                c = ogic_pkg::COORD_W'(wc + $urandom_range(0, ww - 1));
            end
            send_cell(r, c);
            sent++;
            if ($urandom_range(0, 59) == 0) wait_idle();
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, duplicate, four-way merge, neighbor merge
        send_cell(6'd0, 6'd0);
        send_cell(6'd63, 6'd63);
        send_cell(6'd0, 6'd63);
        send_cell(6'd63, 6'd0);
        send_cell(6'd0, 6'd0);
        send_cell(6'd10, 6'd9);
        send_cell(6'd10, 6'd11);
        send_cell(6'd9, 6'd10);
        send_cell(6'd11, 6'd10);
        send_cell(6'd10, 6'd10);
        send_cell(6'd0, 6'd1);
        send_cell(6'd2, 6'd5);

        // shrunk grid: land outside stays counted but is no neighbor
        set_grid(5, 5);
        send_cell(6'd2, 6'd4);
        send_cell(6'd7, 6'd0);
        send_cell(6'd0, 6'd5);
        send_cell(6'd4, 6'd4);

        // zero rows: nothing inside
        set_grid(0, 5);
        send_cell(6'd0, 6'd2);
        send_cell(6'd0, 6'd0);

        // above maximum: clamped to full grid
        set_grid(127, 127);
        send_cell(6'd63, 6'd62);
        send_cell(6'd32, 6'd32);
        send_cell(6'd62, 6'd63);
        send_cell(6'd1, 6'd63);

        set_grid(1, 1);
        send_cell(6'd0, 6'd0);
        send_cell(6'd0, 6'd1);

        run_phase(64, 64, 90, 250);
        run_phase(8, 8, 40, 120);
        run_phase(1, 64, 30, 100);
        run_phase(64, 1, 30, 100);
        run_phase(0, 33, 0, 25);
        run_phase(127, 127, 90, 250);
        run_phase(16, 40, 80, 200);
        run_phase(45, 0, 0, 20);
        run_phase(100, 12, 60, 150);
        run_phase(2, 2, 4, 30);
        run_phase(64, 64, 100, 250);
        run_phase(33, 17, 60, 150);
        run_phase(64, 64, 100, 250);

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[online_grid_island_counter.f]
src/ogic_pkg.sv
src/ogic_if.sv
src/ogic_ram.sv
src/online_grid_island_counter.sv
bench/island_count_checker.sv
bench/tb.sv
